// File: hdl/p1305_pkg.sv
`default_nettype none
package p1305_pkg;
	localparam int LimbW = 26;
	localparam int NumLimbs = 5;
	localparam int AccW = 130;
	localparam int ProdW = 64;
	localparam logic [63:0] ClampLo = 64'h0ffffffc0fffffff;
	localparam logic [63:0] ClampHi = 64'h0ffffffc0ffffffc;

	localparam logic [1:0] CFG_R_LO = 2'd0;
	localparam logic [1:0] CFG_R_HI = 2'd1;
	localparam logic [1:0] CFG_S_LO = 2'd2;
	localparam logic [1:0] CFG_S_HI = 2'd3;

	typedef struct packed {
		logic load;
		logic mac;
		logic clr_col;
		logic [2:0] col;
		logic [2:0] term;
		logic store;
		logic finish;
		logic clear;
	} p1305_cmd_t;
endpackage
`default_nettype wire

// File: hdl/p1305_dp.sv
`default_nettype none
module p1305_dp (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire p1305_pkg::p1305_cmd_t cmd,
	input  wire logic [63:0]           blk_lo,
	input  wire logic [63:0]           blk_hi,
	input  wire logic [4:0]            cnt,
	input  wire logic [63:0]           r_lo,
	input  wire logic [63:0]           r_hi,
	input  wire logic [63:0]           s_lo,
	input  wire logic [63:0]           s_hi,
	output logic [63:0]                tag_lo,
	output logic [63:0]                tag_hi
);
	import p1305_pkg::*;

	logic [129:0] acc_q;
	logic [129:0] h_q;
	logic [129:0] r_q;
	logic [63:0] d_q [NumLimbs];
	logic [63:0] tag_lo_q, tag_hi_q;
	logic [127:0] msg;
	logic [129:0] padded;
	logic [4:0] n;
	logic [7:0] nb;
	logic [26:0] ha;
	logic [25:0] rb;
	logic [28:0] rbs;
	logic [55:0] prod;
	logic [2:0] ri;
	logic [63:0] c;
	logic [63:0] dd [NumLimbs];
	logic [25:0] t [NumLimbs];
	logic [39:0] u;
	logic [129:0] hn;
	logic [130:0] g;
	logic [129:0] fin;
	logic [127:0] tsum;

	always_comb begin
		n = (cnt > 5'd16) ? 5'd16 : cnt;
		nb = {1'b0, n[3:0], 3'b000};
		msg = {blk_hi, blk_lo};
		if (n[4]) begin
			padded = {2'b01, msg};
		end else begin
			padded = {2'b00, msg & ((128'd1 << nb) - 128'd1)} | (130'd1 << nb);
		end
	end

	// One 27x29 partial product per cycle: term j of column col uses h limb j and
	// r limb (col - j) mod 5, scaled by five when it wraps. The h limb is the sum of
	// the accumulator limb and the padded message limb, without carry between limbs.
	always_comb begin
		ha = {1'b0, acc_q[26*cmd.term +: 26]} + {1'b0, h_q[26*cmd.term +: 26]};
		ri = (cmd.col >= cmd.term) ? cmd.col - cmd.term : cmd.col + 3'd5 - cmd.term;
		rb = r_q[26*ri +: 26];
		rbs = (cmd.col >= cmd.term) ? {3'b000, rb} : {1'b0, rb, 2'b00} + {3'b000, rb};
		prod = ha * rbs;
	end

	always_comb begin
		c = '0;
		for (int i = 0; i < NumLimbs; i++) begin
			dd[i] = d_q[i] + c;
			c = dd[i] >> 26;
			t[i] = dd[i][25:0];
		end
		u = {14'd0, t[0]} + 40'(c * 5);
		hn = {t[4], t[3], t[2], t[1], 26'd0} + {90'd0, u};
		g = {1'b0, acc_q} + 131'd5;
		fin = g[130] ? g[129:0] : acc_q;
		tsum = fin[127:0] + {s_hi, s_lo};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.clear) begin
			acc_q <= '0;
		end else if (cmd.store) begin
			acc_q <= hn;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			h_q <= padded;
			r_q <= {2'b00, r_hi & ClampHi, r_lo & ClampLo};
		end
		if (cmd.mac) begin
			d_q[cmd.col] <= (cmd.clr_col ? 64'd0 : d_q[cmd.col]) + 64'(prod);
		end
		if (cmd.finish) begin
			tag_lo_q <= tsum[63:0];
			tag_hi_q <= tsum[127:64];
		end
	end

	assign tag_lo = tag_lo_q;
	assign tag_hi = tag_hi_q;
endmodule
`default_nettype wire

// File: hdl/p1305_ctrl.sv
`default_nettype none
module p1305_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [4:0]             cnt,
	input  wire logic                   last,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output p1305_pkg::p1305_cmd_t       cmd
);
	import p1305_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MAC = 2'd1;
	localparam logic [1:0] S_RED = 2'd2;
	localparam logic [1:0] S_FIN = 2'd3;

	logic [1:0] state_q;
	logic [2:0] col_q, term_q;
	logic last_q, ov_q;
	logic fin_go;

	// The tag register is free when empty or when its beat leaves this cycle.
	assign fin_go = !ov_q || out_ready;
	assign out_valid = ov_q;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.col = col_q;
		cmd.term = term_q;
		cmd.clr_col = (term_q == 3'd0);
		case (state_q)
			S_IDLE: cmd.load = in_valid && in_ready;
			S_MAC: cmd.mac = 1'b1;
			S_RED: cmd.store = 1'b1;
			S_FIN: begin
				cmd.finish = fin_go;
				cmd.clear = fin_go;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q <= '0;
			term_q <= '0;
			last_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && fin_go) begin
				ov_q <= 1'b1;
			end else if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					col_q <= '0;
					term_q <= '0;
					if (in_valid && in_ready) begin
						last_q <= last;
						if (cnt != 5'd0) begin
							state_q <= S_MAC;
						end else if (last) begin
							state_q <= S_FIN;
						end
					end
				end
				S_MAC: begin
					if (term_q == 3'd4) begin
						term_q <= '0;
						if (col_q == 3'd4) begin
							state_q <= S_RED;
						end else begin
							col_q <= col_q + 3'd1;
						end
					end else begin
						term_q <= term_q + 3'd1;
					end
				end
				S_RED: state_q <= last_q ? S_FIN : S_IDLE;
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: hdl/poly1305_mac.sv
`default_nettype none
// Poly1305 authenticator. A block with a nonzero byte count runs from the accept
// cycle through one shared 27x29-bit multiplier forming the partial products of
// (h + m) * r one at a time, then through one carry and reduction step, before
// the next beat is accepted. The last block adds a step for final reduction and
// the s addition. The tag is held in an output register until taken while the
// next message goes on; a further tag waits in its final cycle until that
// register is free.
module poly1305_mac (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] block_low,
	input  wire logic [63:0] block_high,
	input  wire logic [4:0]  byte_count,
	input  wire logic        last_block,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      tag_low,
	output logic [63:0]      tag_high
);
	import p1305_pkg::*;

	logic [63:0] r_lo_q, r_hi_q, s_lo_q, s_hi_q;
	p1305_cmd_t cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_lo_q <= '0;
			r_hi_q <= '0;
			s_lo_q <= '0;
			s_hi_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_R_LO: r_lo_q <= cfg_data;
				CFG_R_HI: r_hi_q <= cfg_data;
				CFG_S_LO: s_lo_q <= cfg_data;
				CFG_S_HI: s_hi_q <= cfg_data;
				default: r_lo_q <= r_lo_q;
			endcase
		end
	end

	p1305_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.cnt(byte_count), .last(last_block), .out_valid(out_valid),
		.out_ready(out_ready), .cmd(cmd)
	);

	p1305_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .blk_lo(block_low),
		.blk_hi(block_high), .cnt(byte_count), .r_lo(r_lo_q), .r_hi(r_hi_q),
		.s_lo(s_lo_q), .s_hi(s_hi_q), .tag_lo(tag_low), .tag_hi(tag_high)
	);
endmodule
`default_nettype wire

// File: tb/sv/poly1305_mac_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module poly1305_mac_tb;
	import p1305_pkg::*;

	localparam logic [129:0] P1305 = (130'd1 << 130) - 130'd5;

	typedef struct {
		logic [63:0] lo;
		logic [63:0] hi;
		logic [4:0]  cnt;
		logic        last;
		bit          known;
		logic [63:0] tag_lo;
		logic [63:0] tag_hi;
	} beat_row_t;

	typedef struct {
		logic [63:0] lo;
		logic [63:0] hi;
	} tag_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = CFG_R_LO;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [63:0] block_low = '0;
	logic [63:0] block_high = '0;
	logic [4:0] byte_count = '0;
	logic last_block = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [63:0] tag_low;
	logic [63:0] tag_high;

	poly1305_mac dut (.*);

	always #6 clk = ~clk;

	logic [63:0] key_r_lo, key_r_hi, key_s_lo, key_s_hi;
	logic [129:0] acc_h;
	tag_t tags_due[$];
	int mismatches = 0;
	int tags_seen = 0;
	bit stim_done = 1'b0;
	int burst_left = 0;

	// Poly1305 step on the tb copy of the state; returns 1 when a tag is produced.
	function automatic bit mac_step(input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] cnt, input logic last, output tag_t t);
		int n;
		logic [255:0] blk, prod, rr;
		logic [129:0] g;
		logic [127:0] tg;
		n = (cnt > 16) ? 16 : cnt;
		if (n > 0) begin
			blk = {128'd0, hi, lo};
			if (n < 16)
				blk &= (256'd1 << (8 * n)) - 1;
			blk |= 256'd1 << (8 * n);
			rr = {128'd0, key_r_hi & ClampHi, key_r_lo & ClampLo};
			prod = ((blk + acc_h) * rr) % P1305;
			acc_h = prod[129:0];
		end
		if (!last)
			return 1'b0;
		g = (acc_h >= P1305) ? acc_h - P1305 : acc_h;
		tg = g[127:0] + {key_s_hi, key_s_lo};
		t.lo = tg[63:0];
		t.hi = tg[127:64];
		acc_h = '0;
		return 1'b1;
	endfunction

	// Leaves cfg_valid high; the caller drops it after the last write.
	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_R_LO: key_r_lo = val;
			CFG_R_HI: key_r_hi = val;
			CFG_S_LO: key_s_lo = val;
			default: key_s_hi = val;
		endcase
		@(negedge clk);
	endtask

	task automatic set_keys(input logic [63:0] a, b, c, d);
		in_valid <= 1'b0;
		burst_left = 0;
		while (tags_due.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		write_reg(CFG_R_LO, a);
		write_reg(CFG_R_HI, b);
		write_reg(CFG_S_LO, c);
		write_reg(CFG_S_HI, d);
		cfg_valid <= 1'b0;
	endtask

	// Holds the beat until accepted; sender gaps come between bursts. Within a
	// burst valid stays high from one beat to the next.
	task automatic send_block(input logic [63:0] lo, hi, input logic [4:0] cnt,
			input logic last, input bit known, input logic [63:0] elo, ehi);
		tag_t t;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		block_low <= lo;
		block_high <= hi;
		byte_count <= cnt;
		last_block <= last;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (mac_step(lo, hi, cnt, last, t)) begin
			if (known) begin
				t.lo = elo;
				t.hi = ehi;
			end
			tags_due.push_back(t);
		end
		@(negedge clk);
	endtask

	// Receiver stall pattern: long ready runs alternating with random stalls.
	int stall_phase = 0;
	always @(negedge clk) begin
		stall_phase <= stall_phase + 1;
		if (stall_phase[6])
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 2) != 0);
	end

	always @(posedge clk) begin
		tag_t e;
		if (arst_n && out_valid && out_ready) begin
			tags_seen++;
			if (tags_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected tag %h_%h", tag_high, tag_low);
			end else begin
				e = tags_due.pop_front();
				if (e.lo !== tag_low || e.hi !== tag_high) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tag mismatch: expected %h_%h got %h_%h",
							e.hi, e.lo, tag_high, tag_low);
				end
			end
		end
	end

	beat_row_t directed[] = '{
		// Reset keys: r = 0, s = 0, so every tag is zero.
		'{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd16, 1'b1, 1'b1, 64'd0, 64'd0},
		'{64'd0, 64'd0, 5'd0, 1'b1, 1'b1, 64'd0, 64'd0},
		'{64'd0, 64'd0, 5'd0, 1'b0, 1'b0, 64'd0, 64'd0}
	};

	beat_row_t keyed[] = '{
		'{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd16, 1'b0, 1'b0, 0, 0},
		'{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd16, 1'b1, 1'b0, 0, 0},
		// Empty message: tag is just s.
		'{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 5'd0, 1'b1, 1'b0, 0, 0},
		'{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd1, 1'b1, 1'b0, 0, 0},
		'{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd7, 1'b1, 1'b0, 0, 0},
		'{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd8, 1'b1, 1'b0, 0, 0},
		'{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd9, 1'b1, 1'b0, 0, 0},
		'{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd15, 1'b0, 1'b0, 0, 0},
		'{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd31, 1'b0, 1'b0, 0, 0},
		'{64'h0, 64'h0, 5'd17, 1'b0, 1'b0, 0, 0},
		'{64'hdeadbeefcafef00d, 64'h0, 5'd0, 1'b0, 1'b0, 0, 0},
		'{64'h1, 64'h8000000000000000, 5'd16, 1'b1, 1'b0, 0, 0},
		'{64'hfffffffffffffffb, 64'hffffffffffffffff, 5'd16, 1'b1, 1'b0, 0, 0}
	};

	function automatic logic [63:0] rand64();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			default: ;
		endcase
		return v;
	endfunction

	initial begin
		int len, kind;
		logic [4:0] cnt;
		key_r_lo = '0;
		key_r_hi = '0;
		key_s_lo = '0;
		key_s_hi = '0;
		acc_h = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed[i])
			send_block(directed[i].lo, directed[i].hi, directed[i].cnt, directed[i].last,
				directed[i].known, directed[i].tag_lo, directed[i].tag_hi);
		set_keys('1, '1, '1, '1);
		foreach (keyed[i])
			send_block(keyed[i].lo, keyed[i].hi, keyed[i].cnt, keyed[i].last, 1'b0, 0, 0);
		set_keys(64'h0, 64'h0, 64'hffffffffffffffff, 64'h0);
		send_block('1, '1, 5'd16, 1'b1, 1'b0, 0, 0);
		for (int ph = 0; ph < 8; ph++) begin
			set_keys(rand64(), rand64(), rand64(), rand64());
			for (int m = 0; m < 60; m++) begin
				kind = $urandom_range(0, 9);
				len = (kind == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
				for (int b = 0; b < len; b++) begin
					cnt = 5'd16;
					if (b == len - 1 || kind == 9)
						cnt = $urandom_range(0, 31);
					send_block(rand64(), rand64(), cnt, b == len - 1, 1'b0, 0, 0);
				end
			end
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		while (tags_due.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire

// File: files.f
hdl/p1305_pkg.sv
hdl/p1305_dp.sv
hdl/p1305_ctrl.sv
hdl/poly1305_mac.sv
tb/sv/poly1305_mac_tb.sv
